/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int PAY_W     = 32;
    localparam int PRIO_W    = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 5;
    localparam int CMP_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int ST_W      = 2;
    localparam int IN_DATA_W = PAY_W + PRIO_W;
    localparam int OUT_RAW_W = PAY_W + PRIO_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] LIMIT_RST = CFG_W'(16);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [PAY_W-1:0]         payload;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    // broadcast to every cell in the row
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry ent;
    } t_cmd;

endpackage

/* hdl/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Sorted priority queue built as a row of DEPTH cells, head in cell 0.
// Input stream: i_s_tuser is the command (0 enqueue, 1 dequeue); i_s_tdata
// carries payload then signed priority. Each accepted word yields exactly one
// result word on the output stream: tuser is the status (done, full, empty),
// tdata the removed payload, removed priority and the occupancy after the step.
// An enqueue lands behind every entry of lower or equal priority: each cell
// compares its priority with the new one and shifts right or loads in place,
// so an insert or a removal updates every cell at once whatever the fill.
// o_m_tvalid rises in the cycle after an input word is accepted; one word is taken
// per cycle while the receiver keeps i_m_tready high. The result register is
// the only buffer: while it holds an untaken word o_s_tready is low.
// Configuration: i_cfg_data is the capacity limit, written when i_cfg_valid
// is high; o_cfg_ready is always high. Write only while the queue is idle.
// Reset empties the queue and sets the limit to 16; held payloads are not
// cleared, only the count.
module sorted_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [spq_pkg::IN_DATA_W-1:0]   i_s_tdata,   // payload, priority_req
    input  logic                            i_s_tuser,   // command
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // removed_payload, removed_priority, occupancy, zero pad
    output logic [spq_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic [spq_pkg::ST_W-1:0]        o_m_tuser,   // status
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [spq_pkg::CFG_W-1:0]       i_cfg_data
);
    import spq_pkg::*;

    logic [CFG_W-1:0]      r_limit;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [ST_W-1:0]       r_m_user;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [CMP_W-1:0]      eff_limit;
    logic [ST_W-1:0]       status;
    t_entry                removed;
    t_cmd                  cmd;

    t_entry                cell_q [DEPTH];
    logic                  cell_gt [DEPTH];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_m_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;

    assign eff_limit = (CMP_W'(r_limit) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(r_limit);
    assign full      = (CMP_W'(r_count) >= eff_limit);
    assign empty     = (r_count == '0);

    assign cmd.ent.payload = i_s_tdata[PAY_W-1:0];
    assign cmd.ent.prio    = i_s_tdata[PAY_W +: PRIO_W];
    assign cmd.enq         = accept && (i_s_tuser == CMD_ENQ) && !full;
    assign cmd.deq         = accept && (i_s_tuser == CMD_DEQ) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic   gt_left;
            t_entry left_q;
            t_entry right_q;
            if (gi == 0) begin : g_head
                assign gt_left = 1'b0;
                assign left_q  = cmd.ent;
            end else begin : g_body
                assign gt_left = cell_gt[gi-1];
                assign left_q  = cell_q[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_q = cell_q[gi];
            end else begin : g_mid
                assign right_q = cell_q[gi+1];
            end
            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_cmd     (cmd),
                .i_occ     (CNT_W'(gi) < r_count),
                .i_tail    (CNT_W'(gi) == r_count),
                .i_gt_left (gt_left),
                .i_left    (left_q),
                .i_right   (right_q),
                .o_gt      (cell_gt[gi]),
                .o_entry   (cell_q[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (cmd.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.deq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        status  = ST_DONE;
        removed = '0;
        if (i_s_tuser == CMD_ENQ) begin
            if (full) begin
                status = ST_FULL;
            end
        end else if (empty) begin
            status = ST_EMPTY;
        end else begin
            removed = cell_q[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RST;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            r_count <= n_count;
            if (accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_data <= OUT_DATA_W'({n_count, removed.prio, removed.payload});
            r_m_user <= status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("entry count beyond depth");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.enq |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("enqueue did not raise count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (cell_q[0].prio <= cell_q[1].prio))
        else $error("head out of order");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_EMPTY)) |->
        (o_m_tdata[PAY_W + PRIO_W +: CNT_W] == '0))
        else $error("empty status with nonzero occupancy");

    a_no_accept_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready) |=> $stable(r_m_data))
        else $error("result overwritten while stalled");
`endif

endmodule

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell (
    input  logic            i_clk,
    input  spq_pkg::t_cmd   i_cmd,
    input  logic            i_occ,
    input  logic            i_tail,
    input  logic            i_gt_left,
    input  spq_pkg::t_entry i_left,
    input  spq_pkg::t_entry i_right,
    output logic            o_gt,
    output spq_pkg::t_entry o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // held entry is served after the new one
    assign o_gt    = i_occ && (r_entry.prio > i_cmd.ent.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq) begin
            if (i_gt_left) begin
                n_entry = i_left;
            end else if (o_gt || i_tail) begin
                n_entry = i_cmd.ent;
            end
        end else if (i_cmd.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* sim/priority_queue_checker.sv */
`timescale 1ns / 1ps

module priority_queue_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [spq_pkg::IN_DATA_W-1:0]  i_s_tdata,   // payload, priority_req
    input  logic                           i_s_tuser,   // command
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // removed_payload, removed_priority, occupancy, zero pad
    input  logic [spq_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [spq_pkg::ST_W-1:0]       i_m_tuser,   // status
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [spq_pkg::CFG_W-1:0]      i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_full_count,
    output int                             o_empty_count,
    output int                             o_peak_fill
);
    import spq_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [PAY_W-1:0]         payload;
        logic signed [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]         occupancy;
    } t_queue_result;

    // shadow copy of the sorted row, head at index 0
    t_entry           held [DEPTH];
    int               held_count;
    logic [CFG_W-1:0] limit_reg;

    t_queue_result    awaited_results [$];
    int               failures;
    int               checked;
    int               full_seen;
    int               empty_seen;
    int               peak_fill;

    function automatic t_queue_result predict_queue_step(logic cmd, t_entry ent);
        t_queue_result r;
        int            eff_limit;
        int            pos;
        r = '0;
        eff_limit = (int'(limit_reg) > DEPTH) ? DEPTH : int'(limit_reg);
        if (cmd == CMD_ENQ) begin
            if (held_count >= eff_limit) begin
                r.status = ST_FULL;
            end else begin
                // walk back past every entry of strictly higher priority
                pos = held_count;
                while (pos > 0 && $signed(held[pos-1].prio) > $signed(ent.prio)) begin
                    held[pos] = held[pos-1];
                    pos--;
                end
                held[pos] = ent;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status  = ST_DONE;
            r.payload = held[0].payload;
            r.prio    = held[0].prio;
            for (int k = 0; k + 1 < held_count; k++) begin
                held[k] = held[k+1];
            end
            held_count--;
        end
        r.occupancy = CNT_W'(held_count);
        return r;
    endfunction

    task automatic report_failure(input string what, input t_queue_result want,
                                  input t_queue_result seen);
        if (failures < 10) begin
            $display("%0t: %s", $realtime, what);
            $display("    status   exp %0d got %0d", want.status, seen.status);
            $display("    payload  exp %h got %h", want.payload, seen.payload);
            $display("    priority exp %0d got %0d", want.prio, seen.prio);
            $display("    count    exp %0d got %0d", want.occupancy, seen.occupancy);
        end
        failures++;
    endtask

    always @(posedge i_clk) begin : watch
        t_queue_result seen;
        t_queue_result want;
        t_entry        ent;
        if (!i_rst_n) begin
            held_count = 0;
            limit_reg  = LIMIT_RST;
            awaited_results.delete();
        end else begin
            // result word first: it always belongs to an earlier input word
            if (i_m_tvalid && i_m_tready) begin
                seen.status    = i_m_tuser;
                seen.payload   = i_m_tdata[PAY_W-1:0];
                seen.prio      = i_m_tdata[PAY_W +: PRIO_W];
                seen.occupancy = i_m_tdata[PAY_W+PRIO_W +: CNT_W];
                checked++;
                if (seen.status == ST_FULL) full_seen++;
                if (seen.status == ST_EMPTY) empty_seen++;
                if (awaited_results.size() == 0) begin
                    report_failure("result word with nothing outstanding", '0, seen);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen !== want) begin
                        report_failure("result word mismatch", want, seen);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                limit_reg = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                ent.payload = i_s_tdata[PAY_W-1:0];
                ent.prio    = i_s_tdata[PAY_W +: PRIO_W];
                awaited_results.push_back(predict_queue_step(i_s_tuser, ent));
                if (held_count > peak_fill) peak_fill = held_count;
            end
        end
        o_pending     <= awaited_results.size();
        o_fail_count  <= failures;
        o_checked     <= checked;
        o_full_count  <= full_seen;
        o_empty_count <= empty_seen;
        o_peak_fill   <= peak_fill;
    end

    initial begin
        failures   = 0;
        checked    = 0;
        full_seen  = 0;
        empty_seen = 0;
        peak_fill  = 0;
        held_count = 0;
        limit_reg  = LIMIT_RST;
    end

endmodule

/* sim/sorted_priority_queue_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 33;

    localparam int PHASE_LIMIT  [PHASES] = '{31, 16, 1, 17, 0, 8, 16, 31, 5, 3, 16, 2};
    localparam int PHASE_ENQ_PCT[PHASES] = '{80, 55, 60, 70, 50, 65, 90, 75, 45, 60, 30, 55};

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [ST_W-1:0]       m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    int fail_count;
    int pending;
    int checked;
    int full_count;
    int empty_count;
    int peak_fill;

    logic steady;
    int   hold_asked;
    int   hold_served;
    int   limit_writes;

    sorted_priority_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    priority_queue_checker u_queue_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_full_count  (full_count),
        .o_empty_count (empty_count),
        .o_peak_fill   (peak_fill)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: random back-pressure plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        hold_served = 0;
        forever begin
            @(posedge clk);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(99) >= 12);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("sorted_priority_queue_tb failed");
        $finish;
    end

    function automatic logic [PRIO_W-1:0] pick_priority(int mode);
        int v;
        case (mode)
            0: begin
                v = int'($urandom);
            end
            1: begin
                // narrow band so that ties are common
                v = int'($urandom_range(0, 6)) - 3;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000;
                    1:       v = 32'h7FFF;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v[PRIO_W-1:0];
    endfunction

    task automatic push_word(input logic cmd, input logic [PAY_W-1:0] pay,
                             input logic [PRIO_W-1:0] pr);
        while (!steady && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pr, pay};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // only while the queue is quiet: every outstanding word has come back
    task automatic write_limit(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    task automatic run_phase(input int words, input int enq_pct, input int prio_mode);
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(99) < enq_pct) begin
                push_word(CMD_ENQ, $urandom, pick_priority(prio_mode));
            end else begin
                push_word(CMD_DEQ, $urandom, PRIO_W'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tuser      <= CMD_ENQ;
        s_tdata      <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        steady       = 1'b0;
        hold_asked   = 0;
        limit_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, ties and draining past empty at the reset limit
        push_word(CMD_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
        push_word(CMD_ENQ, 32'hFFFF_FFFF, 16'h7FFF);
        push_word(CMD_ENQ, 32'h0000_0000, 16'h8000);
        push_word(CMD_ENQ, 32'hA5A5_A5A5, 16'h0000);
        push_word(CMD_ENQ, 32'h5A5A_5A5A, 16'h0000);
        push_word(CMD_ENQ, 32'h0000_0001, 16'hFFFF);
        push_word(CMD_ENQ, 32'h8000_0000, 16'h0001);
        repeat (7) push_word(CMD_DEQ, $urandom, PRIO_W'($urandom));

        // tiny limit, then lowered below the fill, then zero
        write_limit(CFG_W'(2));
        repeat (3) push_word(CMD_ENQ, $urandom, PRIO_W'($urandom));
        write_limit(CFG_W'(1));
        push_word(CMD_ENQ, $urandom, PRIO_W'($urandom));
        repeat (3) push_word(CMD_DEQ, $urandom, PRIO_W'($urandom));
        write_limit(CFG_W'(0));
        push_word(CMD_ENQ, 32'h1234_5678, 16'h8000);

        for (int p = 0; p < PHASES; p++) begin
            write_limit((p == 9) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(PHASE_LIMIT[p]));
            steady = (p == 8);
            if (p == 6) hold_asked++;
            run_phase(PHASE_WORDS, PHASE_ENQ_PCT[p], p % 3);
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);

        $display("%0d queue operations checked over %0d capacity settings", checked,
                 limit_writes + 1);
        $display("%0d full rejections, %0d dequeues on empty, peak fill %0d", full_count,
                 empty_count, peak_fill);
        if (fail_count == 0 && pending == 0) begin
            $display("sorted_priority_queue_tb passed");
        end else begin
            $display("sorted_priority_queue_tb failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
sim/priority_queue_checker.sv
sim/sorted_priority_queue_tb.sv
